[design/gsr_pkg.sv]
`timescale 1ns / 1ps
// Package for the grating sine raster generator: parameter defaults,
// register index codes and the quarter-wave cosine table builder. No dependencies.
package gsr_pkg;

    // Parameter defaults
    localparam int PHASE_BITS_DEF  = 32;
    localparam int LOOKUP_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF  = 12;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int DIM_BITS      = 13;
    localparam int STEP_BITS     = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOR_PHASE_STEP = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VER_PHASE_STEP = 2'd3;

    localparam logic [DIM_BITS-1:0] DIM_RESET = 13'd256;

    // Widest table entry (SAMPLE_BITS up to 25, sign bit dropped)
    localparam int ENTRY_BITS = 24;

    // Half pi in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    // Cosine of (pi/2 * k / 2^lookup_bits) by an eleven-term Taylor series in Q30,
    // rounded half up to sample_bits-1 fraction bits, saturated to full scale.
    // Used at elaboration only, to fill the lookup ROM.
    function automatic logic [ENTRY_BITS-1:0] cos_entry(int unsigned k,
                                                         int unsigned lookup_bits,
                                                         int unsigned sample_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint unsigned smax;
        longint          acc;
        int unsigned     shift;
        x     = (HALF_PI_Q30 * longint'(k)) >> lookup_bits;
        x2    = (x * x) >> 30;
        term  = ONE_Q30;
        acc   = longint'(ONE_Q30);
        shift = 31 - sample_bits;
        smax  = (64'd1 << (sample_bits - 1)) - 64'd1;
        term = ((term * x2) >> 30) / 2;    acc = acc - longint'(term);
        term = ((term * x2) >> 30) / 12;   acc = acc + longint'(term);
        term = ((term * x2) >> 30) / 30;   acc = acc - longint'(term);
        term = ((term * x2) >> 30) / 56;   acc = acc + longint'(term);
        term = ((term * x2) >> 30) / 90;   acc = acc - longint'(term);
        term = ((term * x2) >> 30) / 132;  acc = acc + longint'(term);
        term = ((term * x2) >> 30) / 182;  acc = acc - longint'(term);
        term = ((term * x2) >> 30) / 240;  acc = acc + longint'(term);
        term = ((term * x2) >> 30) / 306;  acc = acc - longint'(term);
        term = ((term * x2) >> 30) / 380;  acc = acc + longint'(term);
        if (acc < 0) begin
            acc = 0;
        end
        r = (longint'(acc) + (64'd1 << (shift - 1))) >> shift;
        if (r > smax) begin
            r = smax;
        end
        return r[ENTRY_BITS-1:0];
    endfunction

endpackage

[design/gsr_in_if.sv]
`timescale 1ns / 1ps
// Input channel of the grating sine raster generator: one restart flag per word.
// Depends on nothing.
interface gsr_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

[design/gsr_out_if.sv]
`timescale 1ns / 1ps
// Output channel of the grating sine raster generator: one pixel per word.
// Depends on nothing; widths come from its parameters.
interface gsr_out_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int COORD_BITS  = 12
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] pixel_value;
    logic        [COORD_BITS-1:0]  column;
    logic        [COORD_BITS-1:0]  row;
    logic                          end_of_line;
    logic                          end_of_frame;

    modport source (output valid, output pixel_value, output column, output row,
                    output end_of_line, output end_of_frame, input ready);
    modport sink   (input valid, input pixel_value, input column, input row,
                    input end_of_line, input end_of_frame, output ready);
endinterface

[design/grating_sine_raster_generator.sv]
`timescale 1ns / 1ps
// Grating sine raster generator: one cosine pixel per accepted word, row-major.
// Words pass stage 1, then the output register; one word per cycle while o_pix.ready.
// The rate is set by the phase accumulator add and the registered cosine ROM read.
// Synchronous active-low reset clears counters, phases and the valid flags of the two
// pipeline stages, and loads width 256, height 256 and zero phase steps. No clearing pass.
// Depends on gsr_pkg, gsr_in_if and gsr_out_if.
module grating_sine_raster_generator #(
    parameter int PHASE_BITS  = gsr_pkg::PHASE_BITS_DEF,
    parameter int LOOKUP_BITS = gsr_pkg::LOOKUP_BITS_DEF,
    parameter int SAMPLE_BITS = gsr_pkg::SAMPLE_BITS_DEF,
    parameter int COORD_BITS  = gsr_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gsr_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [gsr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    gsr_in_if.sink                             i_req,
    gsr_out_if.source                          o_pix
);

    localparam int ROM_DEPTH = (1 << LOOKUP_BITS) + 1;
    localparam int ADDR_BITS = LOOKUP_BITS + 1;
    localparam int DW = (COORD_BITS + 1 > gsr_pkg::DIM_BITS) ? COORD_BITS + 1
                                                              : gsr_pkg::DIM_BITS;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    // Clamp a dimension to 1 .. 2^COORD_BITS and return its last index
    function automatic logic [COORD_BITS-1:0] dim_last(logic [gsr_pkg::DIM_BITS-1:0] v);
        logic [DW-1:0] ext;
        logic [DW-1:0] top;
        logic [DW-1:0] c;
        ext = DW'(v);
        top = DW'(1) << COORD_BITS;
        if (ext == '0) begin
            c = DW'(1);
        end else if (ext > top) begin
            c = top;
        end else begin
            c = ext;
        end
        c = c - DW'(1);
        return c[COORD_BITS-1:0];
    endfunction

    // Align a 32-bit step to the phase width (shift left or truncate right)
    function automatic logic [PHASE_BITS-1:0] align_step(logic [gsr_pkg::STEP_BITS-1:0] s);
        logic [PHASE_BITS+gsr_pkg::STEP_BITS-1:0] t;
        t = {s, {PHASE_BITS{1'b0}}};
        return t[PHASE_BITS+gsr_pkg::STEP_BITS-1:gsr_pkg::STEP_BITS];
    endfunction

    // Configuration, stored in the form the datapath uses
    logic [COORD_BITS-1:0] r_w_last;
    logic [COORD_BITS-1:0] r_h_last;
    logic [PHASE_BITS-1:0] r_hstep;
    logic [PHASE_BITS-1:0] r_vstep;

    // Raster state
    logic [COORD_BITS-1:0] r_col,  n_col;
    logic [COORD_BITS-1:0] r_row,  n_row;
    logic [PHASE_BITS-1:0] r_rsp,  n_rsp;
    logic [PHASE_BITS-1:0] r_pph,  n_pph;

    // Stage 1: ROM data and pixel tags
    logic                   r_s1v;
    logic [SAMPLE_BITS-2:0] r_s1_rom;
    logic                   r_s1_neg;
    logic [COORD_BITS-1:0]  r_s1_col;
    logic [COORD_BITS-1:0]  r_s1_row;
    logic                   r_s1_eol;
    logic                   r_s1_eof;

    // Output register
    logic                          r_ov;
    logic signed [SAMPLE_BITS-1:0] r_o_val;
    logic [COORD_BITS-1:0]         r_o_col;
    logic [COORD_BITS-1:0]         r_o_row;
    logic                          r_o_eol;
    logic                          r_o_eof;

    logic                   en_out;
    logic                   en_s1;
    logic                   accept;
    logic [COORD_BITS-1:0]  cur_col;
    logic [COORD_BITS-1:0]  cur_row;
    logic [PHASE_BITS-1:0]  cur_rsp;
    logic [PHASE_BITS-1:0]  cur_pph;
    logic                   eol;
    logic                   eof;
    logic [1:0]             quad;
    logic [LOOKUP_BITS-1:0] pos;
    logic [ADDR_BITS-1:0]   rom_addr;
    logic                   neg;
    logic [SAMPLE_BITS-1:0] mag;

    // Quarter-wave cosine ROM, filled from the package builder
    logic [SAMPLE_BITS-2:0] cos_rom [ROM_DEPTH];
    for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
        localparam logic [gsr_pkg::ENTRY_BITS-1:0] Entry =
            gsr_pkg::cos_entry(k, LOOKUP_BITS, SAMPLE_BITS);
        assign cos_rom[k] = Entry[SAMPLE_BITS-2:0];
    end

    // Handshake: each stage advances when the next one is empty or moving
    assign en_out      = !r_ov || o_pix.ready;
    assign en_s1       = !r_s1v || en_out;
    assign i_req.ready = en_s1;
    assign accept      = i_req.valid && en_s1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= dim_last(gsr_pkg::DIM_RESET);
            r_h_last <= dim_last(gsr_pkg::DIM_RESET);
            r_hstep  <= '0;
            r_vstep  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gsr_pkg::CFG_IMAGE_WIDTH: begin
                    r_w_last <= dim_last(i_cfg_data[gsr_pkg::DIM_BITS-1:0]);
                end
                gsr_pkg::CFG_IMAGE_HEIGHT: begin
                    r_h_last <= dim_last(i_cfg_data[gsr_pkg::DIM_BITS-1:0]);
                end
                gsr_pkg::CFG_HOR_PHASE_STEP: begin
                    r_hstep <= align_step(i_cfg_data[gsr_pkg::STEP_BITS-1:0]);
                end
                gsr_pkg::CFG_VER_PHASE_STEP: begin
                    r_vstep <= align_step(i_cfg_data[gsr_pkg::STEP_BITS-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // Current pixel position and phase, next raster state
    always_comb begin
        cur_col = i_req.restart ? '0 : r_col;
        cur_row = i_req.restart ? '0 : r_row;
        cur_rsp = i_req.restart ? '0 : r_rsp;
        cur_pph = i_req.restart ? '0 : r_pph;
        eol     = cur_col >= r_w_last;
        eof     = eol && (cur_row >= r_h_last);
        if (eof) begin
            n_col = '0;
            n_row = '0;
            n_rsp = '0;
            n_pph = '0;
        end else if (eol) begin
            n_col = '0;
            n_row = cur_row + COORD_BITS'(1);
            n_rsp = cur_rsp - r_vstep;
            n_pph = n_rsp;
        end else begin
            n_col = cur_col + COORD_BITS'(1);
            n_row = cur_row;
            n_rsp = cur_rsp;
            n_pph = cur_pph + r_hstep;
        end
    end

    // Map phase to quadrant, table address and sign
    always_comb begin
        quad = cur_pph[PHASE_BITS-1 -: 2];
        pos  = cur_pph[PHASE_BITS-3 -: LOOKUP_BITS];
        case (quad)
            QUAD_FIRST: begin
                rom_addr = ADDR_BITS'(pos);
                neg      = 1'b0;
            end
            QUAD_SECOND: begin
                rom_addr = (ADDR_BITS'(1) << LOOKUP_BITS) - ADDR_BITS'(pos);
                neg      = 1'b1;
            end
            QUAD_THIRD: begin
                rom_addr = ADDR_BITS'(pos);
                neg      = 1'b1;
            end
            QUAD_FOURTH: begin
                rom_addr = (ADDR_BITS'(1) << LOOKUP_BITS) - ADDR_BITS'(pos);
                neg      = 1'b0;
            end
            default: begin
                rom_addr = ADDR_BITS'(pos);
                neg      = 1'b0;
            end
        endcase
    end

    // Advance raster state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_rsp <= '0;
            r_pph <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_rsp <= n_rsp;
            r_pph <= n_pph;
        end
    end

    // Stage 1: read the ROM and hold the pixel tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
        end else if (en_s1) begin
            r_s1v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rom <= cos_rom[rom_addr];
            r_s1_neg <= neg;
            r_s1_col <= cur_col;
            r_s1_row <= cur_row;
            r_s1_eol <= eol;
            r_s1_eof <= eof;
        end
    end

    // Zero-extend the ROM magnitude; the quadrant sign is applied in the output register
    assign mag = {1'b0, r_s1_rom};

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_out) begin
            r_ov <= r_s1v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s1v) begin
            r_o_val <= r_s1_neg ? -mag : mag;
            r_o_col <= r_s1_col;
            r_o_row <= r_s1_row;
            r_o_eol <= r_s1_eol;
            r_o_eof <= r_s1_eof;
        end
    end

    assign o_pix.valid        = r_ov;
    assign o_pix.pixel_value  = r_o_val;
    assign o_pix.column       = r_o_col;
    assign o_pix.row          = r_o_row;
    assign o_pix.end_of_line  = r_o_eol;
    assign o_pix.end_of_frame = r_o_eof;

endmodule

[design/gsr_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the grating sine raster generator, bound to the top level.
// Depends on gsr_pkg for the sample width default.
module gsr_checker #(
    parameter int SAMPLE_BITS = gsr_pkg::SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_pixel_value,
    input logic                   i_end_of_line,
    input logic                   i_end_of_frame
);

    localparam logic [SAMPLE_BITS-1:0] MostNeg = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    // A stalled word keeps its pixel value
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pixel_value))
        else $error("stalled output word changed");

    // Last pixel of a frame is also last of its line
    a_eof_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_end_of_frame |-> i_end_of_line)
        else $error("end of frame without end of line");

    // Cosine is symmetric: the most negative code never appears
    a_no_most_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_pixel_value != MostNeg)
        else $error("pixel value out of symmetric range");

endmodule

bind grating_sine_raster_generator gsr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_gsr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_pix.valid),
    .i_out_ready    (o_pix.ready),
    .i_pixel_value  (o_pix.pixel_value),
    .i_end_of_line  (o_pix.end_of_line),
    .i_end_of_frame (o_pix.end_of_frame)
);
